[rtl/ddmt_pkg.sv]
// ----------------------------------------------------------------------------
// ddmt_pkg
// Shared widths, register indexes, reset values and direction codes for the
// differential-drive mixer with command timeout.
// ----------------------------------------------------------------------------
`default_nettype none

package ddmt_pkg;

  // Field widths
  localparam int unsigned CmdW    = 16;   // Q4.12 command
  localparam int unsigned HtW     = 16;   // half track, Q0.16
  localparam int unsigned VelW    = 15;   // max velocity / threshold, Q3.12
  localparam int unsigned DzW     = 16;   // deadzone, Q0.16
  localparam int unsigned TmoW    = 8;    // timeout periods
  localparam int unsigned DutyW   = 8;
  localparam int unsigned DirW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InW     = 32;   // lin_cmd, ang_cmd
  localparam int unsigned OutW    = 24;   // 20 payload bits padded to bytes

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HALF_TRACK   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_VELOCITY = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEADZONE     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ACT_THRESH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT      = 3'd4;

  // Register reset values
  localparam logic [HtW-1:0]  RST_HALF_TRACK   = 16'd2934;
  localparam logic [VelW-1:0] RST_MAX_VELOCITY = 15'd1638;
  localparam logic [DzW-1:0]  RST_DEADZONE     = 16'd6554;
  localparam logic [VelW-1:0] RST_ACT_THRESH   = 15'd4;
  localparam logic [TmoW-1:0] RST_TIMEOUT      = 8'd25;

  // Track direction codes
  localparam logic [DirW-1:0] DIR_STOP = 2'd0;
  localparam logic [DirW-1:0] DIR_FWD  = 2'd1;
  localparam logic [DirW-1:0] DIR_REV  = 2'd2;

endpackage

`default_nettype wire

[rtl/differential_drive_mixer_timeout.sv]
// An active item runs multiply, mix and normalize, then deadzone, divide and
// write-back once per track on the shared 8-step restoring divider, then the
// output load; an idle item goes straight to the output load.
// The input stays not-ready while an item is in work; a finished result
// waits in the output register while the next item is taken.
// Reset (rst, synchronous, active high) restores register defaults and
// clears held drive, idle count and output valid.
// ----------------------------------------------------------------------------
// differential_drive_mixer_timeout
// Mixes linear/angular commands into per-track PWM duty and direction, with
// deadzone, normalization and an idle-period timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_mixer_timeout (
  input  wire                            clk,
  input  wire                            rst,
  // configuration write channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [ddmt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire  [ddmt_pkg::CfgW-1:0]      cfg_data,
  // command items
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [ddmt_pkg::InW-1:0]       s_axis_tdata,   // lin_cmd[15:0], ang_cmd[31:16]
  // drive items
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [ddmt_pkg::OutW-1:0]      m_axis_tdata,   // right_duty[7:0], right_dir[9:8],
                                                         // left_duty[17:10], left_dir[19:18]
  output logic                           m_axis_tuser    // timed_out[0]
);

  import ddmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MIX, S_DEN, S_DZ, S_DIV, S_WB, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [HtW-1:0]  half_track;
  logic [VelW-1:0] max_velocity;
  logic [DzW-1:0]  deadzone;
  logic [VelW-1:0] act_thresh;
  logic [TmoW-1:0] timeout_periods;

  // held drive and idle count
  logic [DutyW-1:0] held_right_duty, held_left_duty;
  logic [DirW-1:0]  held_right_dir, held_left_dir;
  logic [TmoW-1:0]  idle_periods;
  logic             tout;

  // datapath registers
  logic signed [CmdW-1:0]   lin, ang;
  logic signed [32:0]       prod;
  logic signed [17:0]       vr, vl;
  logic [16:0]              denom;
  logic                     side;       // 0 right, 1 left
  logic                     stop;
  logic [24:0]              rem;
  logic [23:0]              dsh;
  logic [DutyW-1:0]         quot;
  logic [2:0]               step;

  // output register
  logic [DutyW-1:0] out_rd, out_ld;
  logic [DirW-1:0]  out_rdir, out_ldir;

  // input decode and activity test
  logic signed [CmdW-1:0] in_lin, in_ang;
  logic [CmdW:0]          in_lin_mag, in_ang_mag;
  logic                   in_active;
  logic [TmoW-1:0]        idle_inc;

  assign in_lin     = s_axis_tdata[15:0];
  assign in_ang     = s_axis_tdata[31:16];
  assign in_lin_mag = in_lin[CmdW-1] ? (17'd0 - {in_lin[CmdW-1], in_lin})
                                     : {1'b0, in_lin};
  assign in_ang_mag = in_ang[CmdW-1] ? (17'd0 - {in_ang[CmdW-1], in_ang})
                                     : {1'b0, in_ang};
  assign in_active  = (in_lin_mag > {2'b00, act_thresh}) ||
                      (in_ang_mag > {2'b00, act_thresh});
  assign idle_inc   = (idle_periods == '1) ? idle_periods : idle_periods + 8'd1;

  // mixing terms
  logic signed [16:0] turn;
  logic signed [17:0] vr_sum, vl_sum;
  assign turn   = prod[32:16];   // arithmetic shift, floors toward minus infinity
  assign vr_sum = {{2{lin[CmdW-1]}}, lin} + {turn[16], turn};
  assign vl_sum = {{2{lin[CmdW-1]}}, lin} - {turn[16], turn};

  // track magnitudes and normalizer
  logic [16:0] ar, al, dmax, sel_mag;
  logic signed [17:0] sel_v;
  assign ar      = vr[17] ? 17'(18'd0 - vr) : vr[16:0];
  assign al      = vl[17] ? 17'(18'd0 - vl) : vl[16:0];
  always_comb begin
    dmax = {2'b00, max_velocity};
    if (ar > dmax) dmax = ar;
    if (al > dmax) dmax = al;
    if (dmax == '0) dmax = 17'd1;
  end
  assign sel_v   = side ? vl : vr;
  assign sel_mag = side ? al : ar;

  // deadzone compare and dividend
  logic [32:0] dz_prod;
  logic        dz_stop;
  logic [24:0] dividend;
  assign dz_prod  = {17'd0, deadzone} * {16'd0, denom};
  assign dz_stop  = {sel_mag, 16'd0} < dz_prod;
  assign dividend = {sel_mag, 8'd0} - {8'd0, sel_mag};

  // shared divider step
  logic        div_ge;
  logic [24:0] div_diff;
  assign div_ge   = rem >= {1'b0, dsh};
  assign div_diff = rem - {1'b0, dsh};

  // result of the current track
  logic [DutyW-1:0] wb_duty;
  logic [DirW-1:0]  wb_dir;
  assign wb_duty = stop ? '0 : quot;
  assign wb_dir  = stop ? DIR_STOP :
                   ((!sel_v[17] && sel_v != '0) ? DIR_FWD : DIR_REV);

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {4'd0, out_ldir, out_ld, out_rdir, out_rd};

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      half_track      <= RST_HALF_TRACK;
      max_velocity    <= RST_MAX_VELOCITY;
      deadzone        <= RST_DEADZONE;
      act_thresh      <= RST_ACT_THRESH;
      timeout_periods <= RST_TIMEOUT;
      held_right_duty <= '0;
      held_right_dir  <= DIR_STOP;
      held_left_duty  <= '0;
      held_left_dir   <= DIR_STOP;
      idle_periods    <= '0;
      tout            <= 1'b0;
      side            <= 1'b0;
      step            <= '0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_HALF_TRACK:   half_track      <= cfg_data;
          REG_MAX_VELOCITY: max_velocity    <= cfg_data[VelW-1:0];
          REG_DEADZONE:     deadzone        <= cfg_data;
          REG_ACT_THRESH:   act_thresh      <= cfg_data[VelW-1:0];
          REG_TIMEOUT:      timeout_periods <= cfg_data[TmoW-1:0];
          default: ;
        endcase
      end

      // S_FIN drives valid itself
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            lin <= in_lin;
            ang <= in_ang;
            if (in_active) begin
              state <= S_MUL;
            end else begin
              // idle period: count and maybe force zero drive
              idle_periods <= idle_inc;
              if (idle_inc > timeout_periods) begin
                held_right_duty <= '0;
                held_right_dir  <= DIR_STOP;
                held_left_duty  <= '0;
                held_left_dir   <= DIR_STOP;
                tout            <= 1'b1;
              end else begin
                tout <= 1'b0;
              end
              state <= S_FIN;
            end
          end
        end
        S_MUL: begin
          prod  <= 33'(ang) * 33'($signed({1'b0, half_track}));
          state <= S_MIX;
        end
        S_MIX: begin
          vr    <= vr_sum;
          vl    <= vl_sum;
          state <= S_DEN;
        end
        S_DEN: begin
          denom <= dmax;
          side  <= 1'b0;
          state <= S_DZ;
        end
        S_DZ: begin
          stop  <= dz_stop;
          rem   <= dividend;
          dsh   <= {denom, 7'd0};
          quot  <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_ge) rem <= div_diff;
          quot <= {quot[DutyW-2:0], div_ge};
          dsh  <= dsh >> 1;
          step <= step + 3'd1;
          if (step == 3'd7) state <= S_WB;
        end
        S_WB: begin
          if (!side) begin
            held_right_duty <= wb_duty;
            held_right_dir  <= wb_dir;
            side            <= 1'b1;
            state           <= S_DZ;
          end else begin
            held_left_duty <= wb_duty;
            held_left_dir  <= wb_dir;
            idle_periods   <= '0;
            tout           <= 1'b0;
            state          <= S_FIN;
          end
        end
        S_FIN: begin
          // load the output register once it is free
          if (!m_axis_tvalid || m_axis_tready) begin
            out_rd        <= held_right_duty;
            out_rdir      <= held_right_dir;
            out_ld        <= held_left_duty;
            out_ldir      <= held_left_dir;
            m_axis_tuser  <= tout;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ddmt_checker.sv]
// ----------------------------------------------------------------------------
// ddmt_checker
// Port-level checks on the mixer: output hold, code legality, stop and
// timeout consistency, input not ready right after an accept.
// ----------------------------------------------------------------------------
`default_nettype none

module ddmt_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        s_axis_tvalid,
  input wire                        s_axis_tready,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [ddmt_pkg::OutW-1:0]   m_axis_tdata,
  input wire                        m_axis_tuser
);

  import ddmt_pkg::*;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // direction codes are stop, forward or reverse
  a_dir_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9:8] != 2'd3) && (m_axis_tdata[19:18] != 2'd3))
    else $error("illegal direction code");

  // a stopped track has zero duty
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[9:8] == DIR_STOP || m_axis_tdata[19:18] == DIR_STOP)
    |-> ((m_axis_tdata[9:8] != DIR_STOP) || (m_axis_tdata[7:0] == 8'd0)) &&
        ((m_axis_tdata[19:18] != DIR_STOP) || (m_axis_tdata[17:10] == 8'd0)))
    else $error("stopped track with nonzero duty");

  // timeout forces all drive to zero
  a_tout_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[19:0] == 20'd0)
    else $error("timeout with nonzero drive");

  // after taking an item the block is not ready in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

endmodule

bind differential_drive_mixer_timeout ddmt_checker u_ddmt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
